### src/ste_pkg.sv
// Shared constants, types and helper functions for the square transposition encoder.
package ste_pkg;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5a;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7a;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CASE_OFS = CH_LO_A - CH_UP_A;

  typedef struct packed {
    logic       keep;
    logic [7:0] ch;
  } fold_t;

  function automatic fold_t fold_char(input logic [7:0] ch);
    fold_t f;
    f.keep = 1'b0;
    f.ch   = ch;
    if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
      f.keep = 1'b1;
      f.ch   = ch + CASE_OFS;
    end else if ((ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_D0 && ch <= CH_D9)) begin
      f.keep = 1'b1;
    end
    return f;
  endfunction

  function automatic int ceil_root(input int n);
    int c;
    c = 0;
    while (c * c < n) c++;
    return c;
  endfunction

endpackage

### src/ste_text_mem.sv
// Text buffer: one write port, one registered read port.
module ste_text_mem #(
  parameter int MAX_TEXT = 48,
  parameter int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [MAX_TEXT];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/ste_geom.sv
// Rectangle geometry: ceiling square root of the text length and row count.
module ste_geom #(
  parameter int MAX_TEXT = 48,
  parameter int LW = $clog2(MAX_TEXT + 1),
  parameter int CW = $clog2(ste_pkg::ceil_root(MAX_TEXT) + 1)
) (
  input  logic          clk,
  input  logic          load,
  input  logic [LW-1:0] len,
  output logic [CW-1:0] cols,
  output logic [CW-1:0] rows
);
  import ste_pkg::*;

  localparam int CMAX = ceil_root(MAX_TEXT);

  logic [CW-1:0] cols_nxt, rows_nxt;
  logic [CW-1:0] cols_r, rows_r;

  always_comb begin
    cols_nxt = '0;
    rows_nxt = '0;
    for (int c = CMAX; c >= 1; c--) begin
      if (c * c >= int'(len)) begin
        cols_nxt = CW'(c);
        rows_nxt = ((c - 1) * c >= int'(len)) ? CW'(c - 1) : CW'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign cols = cols_r;
  assign rows = rows_r;

endmodule

### src/square_transposition_encoder_core.sv
// Top level: text intake, buffer and column-by-column ciphertext readout.
//
//   channel | direction | payload                                         | handshake
//   in      | input     | in_char, in_end_of_text                         | in_valid/in_ready
//   out     | output    | out_char, out_last_char, out_empty_text,        | out_valid/out_ready
//           |           | out_overflowed                                  |
//
// Intake takes one request per cycle while idle. An end-of-text request passes through
// the geometry state, then each result steps through buffer read, output load and
// the output handshake (held while out_ready is low); an empty text goes straight to
// the handshake. Up to 55 results per text.
// The input is held off from the end request until the last result is taken.
// Synchronous active-low reset empties the buffer count; buffer contents are not cleared.
module square_transposition_encoder_core #(
  parameter int MAX_TEXT = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char,
  output logic       out_empty_text,
  output logic       out_overflowed
);
  import ste_pkg::*;

  localparam int AW   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int LW   = $clog2(MAX_TEXT + 1);
  localparam int CMAX = ceil_root(MAX_TEXT);
  localparam int CW   = $clog2(CMAX + 1);
  localparam int IDXW = (CMAX > 1) ? $clog2(CMAX * CMAX) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_GEO, ST_RD, ST_LD, ST_WT} state_t;

  state_t          state_r;
  logic [LW-1:0]   count_r;
  logic            ovf_r;
  logic [CW-1:0]   col_r, row_r;
  logic [IDXW-1:0] idx_r;
  logic            gap_r;
  logic            sp_r;
  logic            lastpos_r;
  logic            out_valid_r;
  logic [7:0]      out_char_r;
  logic            out_last_r, out_empty_r, out_ovf_r;

  fold_t         fold;
  logic          in_acc;
  logic          mem_we;
  logic [7:0]    mem_q;
  logic [CW-1:0] cols, rows;
  logic          at_last_row, at_last_col;

  assign fold     = fold_char(in_char);
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign mem_we   = in_acc && fold.keep && (count_r < LW'(MAX_TEXT));

  ste_text_mem #(.MAX_TEXT(MAX_TEXT), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (fold.ch),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_q)
  );

  ste_geom #(.MAX_TEXT(MAX_TEXT), .LW(LW), .CW(CW)) u_geom (
    .clk  (clk),
    .load (state_r == ST_GEO),
    .len  (count_r),
    .cols (cols),
    .rows (rows)
  );

  assign at_last_row = (row_r == rows - CW'(1));
  assign at_last_col = (col_r == cols - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (mem_we) begin
              count_r <= count_r + LW'(1);
            end else if (fold.keep) begin
              ovf_r <= 1'b1;
            end
            if (in_end_of_text) begin
              state_r <= ST_GEO;
            end
          end
        end
        ST_GEO: begin
          col_r <= '0;
          row_r <= '0;
          idx_r <= '0;
          gap_r <= 1'b0;
          if (count_r == '0) begin
            out_char_r  <= '0;
            out_last_r  <= 1'b1;
            out_empty_r <= 1'b1;
            out_ovf_r   <= ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_WT;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          sp_r      <= gap_r || (int'(idx_r) >= int'(count_r));
          lastpos_r <= !gap_r && at_last_row && at_last_col;
          state_r   <= ST_LD;
        end
        ST_LD: begin
          out_char_r  <= sp_r ? CH_SP : mem_q;
          out_last_r  <= lastpos_r;
          out_empty_r <= 1'b0;
          out_ovf_r   <= ovf_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_WT;
        end
        ST_WT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_RD;
              if (gap_r) begin
                gap_r <= 1'b0;
                col_r <= col_r + CW'(1);
                row_r <= '0;
                idx_r <= IDXW'(col_r + CW'(1));
              end else if (at_last_row) begin
                gap_r <= 1'b1;
              end else begin
                row_r <= row_r + CW'(1);
                idx_r <= IDXW'(idx_r + IDXW'(cols));
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last_char  = out_last_r;
  assign out_empty_text = out_empty_r;
  assign out_overflowed = out_ovf_r;

endmodule

### tb/ste_cipher_checker.sv
// Request/result monitor for the square transposition encoder: predicts the ciphertext.
module ste_cipher_checker #(
  parameter int MAX_TEXT = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_last_char,
  input  logic       out_empty_text,
  input  logic       out_overflowed,
  output int         fail_count,
  output int         pending
);
  import ste_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       ovf;
  } cipher_t;

  cipher_t    cipher_q[$];
  logic [7:0] text_buf [MAX_TEXT];
  int         text_len;
  logic       ovf_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    text_len   = 0;
    ovf_seen   = 1'b0;
  end

  task automatic predict_cipher(input logic [7:0] ch, input logic eot);
    logic [7:0] lc;
    logic       kept;
    int         cols;
    int         rows;
    int         idx;
    int         c;
    int         r;
    cipher_t    res;
    kept = 1'b1;
    lc   = ch;
    if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
      lc = ch | 8'h20;
    end else if (!(ch inside {[CH_LO_A:CH_LO_Z], [CH_D0:CH_D9]})) begin
      kept = 1'b0;
    end
    if (kept) begin
      if (text_len < MAX_TEXT) begin
        text_buf[text_len] = lc;
        text_len++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (!eot) return;
    if (text_len == 0) begin
      res = '{ch: 8'h00, last: 1'b1, empty: 1'b1, ovf: ovf_seen};
      cipher_q = {cipher_q, res};
    end else begin
      cols = 1;
      while (cols * cols < text_len) cols++;
      rows = ((cols - 1) * cols >= text_len) ? cols - 1 : cols;
      for (c = 0; c < cols; c++) begin
        for (r = 0; r < rows; r++) begin
          idx = r * cols + c;
          res.ch    = (idx < text_len) ? text_buf[idx] : CH_SP;
          res.last  = (c == cols - 1) && (r == rows - 1);
          res.empty = 1'b0;
          res.ovf   = ovf_seen;
          cipher_q = {cipher_q, res};
        end
        if (c < cols - 1) begin
          res = '{ch: CH_SP, last: 1'b0, empty: 1'b0, ovf: ovf_seen};
          cipher_q = {cipher_q, res};
        end
      end
    end
    text_len = 0;
    ovf_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    cipher_t want;
    cipher_t got;
    if (!rst_n) begin
      text_len = 0;
      ovf_seen = 1'b0;
      cipher_q.delete();
    end else begin
      if (in_valid && in_ready) predict_cipher(in_char, in_end_of_text);
      if (out_valid && out_ready) begin
        got = '{ch: out_char, last: out_last_char, empty: out_empty_text,
                ovf: out_overflowed};
        if (cipher_q.size() == 0) begin
          fail_count++;
          $display({"%0t: unexpected result: expected none, ",
                    "actual char=%h last=%b empty=%b ovf=%b"},
                   $time, got.ch, got.last, got.empty, got.ovf);
        end else begin
          want = cipher_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display({"%0t: result mismatch: expected char=%h last=%b empty=%b ovf=%b, ",
                      "actual char=%h last=%b empty=%b ovf=%b"},
                     $time, want.ch, want.last, want.empty, want.ovf,
                     got.ch, got.last, got.empty, got.ovf);
          end
        end
      end
    end
    pending <= cipher_q.size();
  end

endmodule

### tb/square_transposition_encoder_core_test.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and final verdict.
module square_transposition_encoder_core_test;
  import ste_pkg::*;

  localparam int MAX_TEXT    = 48;
  localparam int NUM_ITEMS   = 330;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SQUEEZE_LEN = 500;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_char        = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_char;
  logic       out_last_char;
  logic       out_empty_text;
  logic       out_overflowed;

  int   fail_count;
  int   pending;
  int   cycles       = 0;
  int   burst_left   = 0;
  int   sent         = 0;
  logic squeeze_req  = 1'b0;

  square_transposition_encoder_core #(.MAX_TEXT(MAX_TEXT)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_empty_text (out_empty_text),
    .out_overflowed (out_overflowed)
  );

  ste_cipher_checker #(.MAX_TEXT(MAX_TEXT)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_empty_text (out_empty_text),
    .out_overflowed (out_overflowed),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] alnum_byte();
    case ($urandom_range(0, 2))
      0:       return CH_UP_A + 8'($urandom_range(0, 25));
      1:       return CH_LO_A + 8'($urandom_range(0, 25));
      default: return CH_D0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic send_req(input logic [7:0] ch, input logic eot);
    in_valid       <= 1'b1;
    in_char        <= ch;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_text();
    int         kind;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       n = 0;
      7:       n = $urandom_range(13, 30);
      8:       n = MAX_TEXT;
      9:       n = $urandom_range(MAX_TEXT + 1, MAX_TEXT + 8);
      default: n = $urandom_range(1, 12);
    endcase
    for (int i = 0; i < n; i++) begin
      b = (kind >= 8 || $urandom_range(0, 4) != 0) ? alnum_byte() : 8'($urandom_range(0, 255));
      send_req(b, 1'b0);
    end
    if (kind == 8) b = CH_SP;
    else b = $urandom_range(0, 1) ? alnum_byte() : 8'($urandom_range(0, 255));
    send_req(b, 1'b1);
  endtask

  // directed: empty text, single char, range edges with noise, short and square texts
  logic [8:0] opening [22] = '{
    {1'b1, 8'h21},
    {1'b1, CH_UP_A},
    {1'b0, CH_UP_Z}, {1'b0, 8'h40}, {1'b0, CH_LO_A}, {1'b0, 8'h5b}, {1'b0, CH_LO_Z},
    {1'b0, 8'h60}, {1'b0, CH_D0}, {1'b0, 8'h7b}, {1'b0, CH_D9}, {1'b0, 8'h2f},
    {1'b0, 8'h3a}, {1'b0, 8'h00}, {1'b0, 8'hff}, {1'b1, 8'h2e},
    {1'b0, 8'h48}, {1'b1, 8'h69},
    {1'b0, 8'h61}, {1'b0, 8'h62}, {1'b0, 8'h63}, {1'b1, 8'h64}
  };

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening[i]) send_req(opening[i][7:0], opening[i][8]);
    squeeze_req = 1'b1;
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) send_req(8'h2d, 1'b0);
      send_text();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result back-pressure: changing stall patterns, with one long hold-off once the directed opening is sent
  initial begin
    int   mode;
    int   left;
    int   hold;
    logic squeeze_done;
    mode         = 0;
    left         = 0;
    hold         = 0;
    squeeze_done = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold         = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

endmodule
